// File: design/hsvc_pkg.sv
`timescale 1ns / 1ps
package hsvc_pkg;

  localparam int ChanW      = 8;
  localparam int QuoW       = 8;
  localparam int NumerW     = 17;
  localparam int DenW       = 9;
  localparam int HueRegW    = 18;
  localparam int SatRegW    = 16;
  localparam int BoundW     = 9;
  localparam int MaxHueRegs = 7;

  // register index of the wall saturation window
  localparam logic [2:0] CfgSatWin = 3'd7;

  localparam logic [2:0] ClsWall    = 3'd0;
  localparam logic [2:0] ClsNoMatch = 3'd7;

  localparam logic [9:0] HalfTurn = 10'd180;
  localparam logic [8:0] HueBias  = 9'd60;

  localparam logic [MaxHueRegs-1:0][HueRegW-1:0] HueWinReset = {
    18'd3064, 18'd25625, 18'd64050, 18'd82045, 18'd12815, 18'd5125, 18'd92662
  };
  localparam logic [SatRegW-1:0] SatWinReset = 16'd20480;

  typedef struct packed {
    logic             grey;
    logic             black;
    logic [ChanW-1:0] value;
  } hsvc_ctl_t;

  typedef struct packed {
    logic [NumerW-1:0] sat_num;
    logic [DenW-1:0]   sat_den;
    logic [NumerW-1:0] hue_num;
    logic [DenW-1:0]   hue_den;
  } hsvc_div_t;

  typedef struct packed {
    logic [2:0]       color_class;
    logic [ChanW-1:0] hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] brightness;
  } hsvc_res_t;

endpackage

// File: design/hsvc_prep.sv
`timescale 1ns / 1ps
module hsvc_prep (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  output logic                  out_valid,
  output hsvc_pkg::hsvc_ctl_t   out_ctl,
  output hsvc_pkg::hsvc_div_t   out_ops
);

  // stage 1: max, min and the signed hue numerator
  logic [7:0]  mx_nxt, mn_nxt, diff_nxt;
  logic [11:0] num_nxt;
  logic        s1_valid_r;
  logic [7:0]  mx_r, diff_r;
  logic [11:0] num_r;

  always_comb begin
    mx_nxt = red;
    mn_nxt = red;
    if (green > mx_nxt) mx_nxt = green;
    if (blue > mx_nxt) mx_nxt = blue;
    if (green < mn_nxt) mn_nxt = green;
    if (blue < mn_nxt) mn_nxt = blue;
    diff_nxt = mx_nxt - mn_nxt;
    if (mx_nxt == red) begin
      num_nxt = 12'(green) - 12'(blue);
    end else if (mx_nxt == green) begin
      num_nxt = 12'(blue) - 12'(red) + {3'b0, diff_nxt, 1'b0};
    end else begin
      num_nxt = 12'(red) - 12'(green) + {2'b0, diff_nxt, 2'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r   <= mx_nxt;
      diff_r <= diff_nxt;
      num_r  <= num_nxt;
    end
  end

  // stage 2: dividends and divisors for both quotients
  hsvc_pkg::hsvc_div_t ops_nxt, ops_r;
  hsvc_pkg::hsvc_ctl_t ctl_nxt, ctl_r;
  logic [18:0]         hue_sum;
  logic                s2_valid_r;

  always_comb begin
    // wraps in 19 bits; the true value is nonnegative and below 2^17
    hue_sum = {{7{num_r[11]}}, num_r} * 19'd60 + 19'(diff_r) * 19'd121;
    ops_nxt.sat_num = 17'(diff_r) * 17'd510 + 17'(mx_r);
    ops_nxt.sat_den = {mx_r, 1'b0};
    ops_nxt.hue_num = hue_sum[16:0];
    ops_nxt.hue_den = {diff_r, 1'b0};
    ctl_nxt.grey    = (diff_r == 8'd0);
    ctl_nxt.black   = (mx_r == 8'd0);
    ctl_nxt.value   = mx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ops_r <= ops_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_ctl   = ctl_r;
  assign out_ops   = ops_r;

endmodule

// File: design/hsvc_div.sv
`timescale 1ns / 1ps
module hsvc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  hsvc_pkg::hsvc_div_t   in_ops,
  input  hsvc_pkg::hsvc_ctl_t   in_ctl,
  output logic                  out_valid,
  output hsvc_pkg::hsvc_ctl_t   out_ctl,
  output logic [7:0]            out_sat_q,
  output logic [7:0]            out_hue_q
);

  // restoring division, one quotient bit per stage, both lanes side by side
  localparam int Steps = hsvc_pkg::QuoW;
  localparam int NW    = hsvc_pkg::NumerW;
  localparam int DW    = hsvc_pkg::DenW;

  logic                vld   [Steps+1];
  hsvc_pkg::hsvc_ctl_t ctl   [Steps+1];
  logic [NW-1:0]       rem_s [Steps];
  logic [NW-1:0]       rem_h [Steps];
  logic [DW-1:0]       den_s [Steps];
  logic [DW-1:0]       den_h [Steps];
  logic [Steps-1:0]    q_s   [Steps+1];
  logic [Steps-1:0]    q_h   [Steps+1];

  logic                vld_r   [Steps];
  hsvc_pkg::hsvc_ctl_t ctl_r   [Steps];
  logic [Steps-1:0]    q_s_r   [Steps];
  logic [Steps-1:0]    q_h_r   [Steps];

  assign vld[0]   = in_valid;
  assign ctl[0]   = in_ctl;
  assign rem_s[0] = in_ops.sat_num;
  assign rem_h[0] = in_ops.hue_num;
  assign den_s[0] = in_ops.sat_den;
  assign den_h[0] = in_ops.hue_den;
  assign q_s[0]   = '0;
  assign q_h[0]   = '0;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int Sh = Steps - 1 - k;
    logic [NW-1:0] trial_s, trial_h;
    logic          take_s, take_h;

    assign trial_s = NW'(den_s[k]) << Sh;
    assign trial_h = NW'(den_h[k]) << Sh;
    assign take_s  = (rem_s[k] >= trial_s);
    assign take_h  = (rem_h[k] >= trial_h);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[k] <= ctl[k];
        q_s_r[k] <= {q_s[k][Steps-2:0], take_s};
        q_h_r[k] <= {q_h[k][Steps-2:0], take_h};
      end
    end

    assign vld[k+1] = vld_r[k];
    assign ctl[k+1] = ctl_r[k];
    assign q_s[k+1] = q_s_r[k];
    assign q_h[k+1] = q_h_r[k];

    // the last stage leaves no remainder behind
    if (k < Steps - 1) begin : g_rem
      logic [NW-1:0] rem_s_r, rem_h_r;
      logic [DW-1:0] den_s_r, den_h_r;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_s_r <= take_s ? (rem_s[k] - trial_s) : rem_s[k];
          rem_h_r <= take_h ? (rem_h[k] - trial_h) : rem_h[k];
          den_s_r <= den_s[k];
          den_h_r <= den_h[k];
        end
      end

      assign rem_s[k+1] = rem_s_r;
      assign rem_h[k+1] = rem_h_r;
      assign den_s[k+1] = den_s_r;
      assign den_h[k+1] = den_h_r;
    end
  end

  assign out_valid = vld[Steps];
  assign out_ctl   = ctl[Steps];
  assign out_sat_q = q_s[Steps];
  assign out_hue_q = q_h[Steps];

endmodule

// File: design/hsvc_classify.sv
`timescale 1ns / 1ps
module hsvc_classify #(
  parameter int NUM_CLASSES = 7
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          en,
  input  logic                                          in_valid,
  input  hsvc_pkg::hsvc_ctl_t                           in_ctl,
  input  logic [7:0]                                    in_sat_q,
  input  logic [7:0]                                    in_hue_q,
  input  logic [NUM_CLASSES-1:0][hsvc_pkg::HueRegW-1:0] hue_win,
  input  logic [hsvc_pkg::SatRegW-1:0]                  sat_win,
  output logic                                          out_valid,
  output hsvc_pkg::hsvc_res_t                           out_res
);

  localparam int BW = hsvc_pkg::BoundW;

  // stage A: remove the hue bias, wrap, and force grey and black cases
  logic [8:0] hue_diff, hue_wrap;
  logic [7:0] a_hue_nxt, a_sat_nxt;
  logic       a_valid_r;
  logic [7:0] a_hue_r, a_sat_r, a_val_r;

  always_comb begin
    hue_diff  = {1'b0, in_hue_q} - hsvc_pkg::HueBias;
    hue_wrap  = hue_diff[8] ? (hue_diff + hsvc_pkg::HalfTurn[8:0]) : hue_diff;
    a_hue_nxt = in_ctl.grey ? 8'd0 : hue_wrap[7:0];
    a_sat_nxt = in_ctl.black ? 8'd0 : in_sat_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_hue_r <= a_hue_nxt;
      a_sat_r <= a_sat_nxt;
      a_val_r <= in_ctl.value;
    end
  end

  // stage B: window tests, independent per class, later class wins
  logic [NUM_CLASSES-1:0] hit;
  logic                   sat_ok;
  logic [2:0]             cls_nxt;
  logic                   b_valid_r;
  hsvc_pkg::hsvc_res_t    res_r;

  assign sat_ok = (a_sat_r >= sat_win[7:0]) && (a_sat_r <= sat_win[15:8]);

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_win
    logic signed [9:0] lo, hi, hv, hh;
    assign lo = 10'(signed'(hue_win[c][BW-1:0]));
    assign hi = 10'(signed'(hue_win[c][2*BW-1:BW]));
    assign hv = signed'({2'b00, a_hue_r});
    assign hh = (hv > hi) ? (hv - signed'(hsvc_pkg::HalfTurn)) : hv;
    assign hit[c] = (hh >= lo) && (hh <= hi);
  end

  always_comb begin
    cls_nxt = hsvc_pkg::ClsNoMatch;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (hit[c]) begin
        if (c == 0) begin
          if (sat_ok) cls_nxt = hsvc_pkg::ClsWall;
        end else begin
          cls_nxt = 3'(c);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.color_class <= cls_nxt;
      res_r.hue         <= a_hue_r;
      res_r.saturation  <= a_sat_r;
      res_r.brightness  <= a_val_r;
    end
  end

  assign out_valid = b_valid_r;
  assign out_res   = res_r;

endmodule

// File: design/hsv_hue_range_color_classifier.sv
`timescale 1ns / 1ps
// RGB to HSV color classifier. Each transfer on the input stream carries one
// 8-bit RGB color; one result follows per color, in order, with the class code
// (0 wall, 1 orange, 2 yellow, 3 purple, 4 blue, 5 green, 6 red, 7 no match),
// hue in units of two degrees, saturation and brightness. The block takes one
// color per clock cycle while in_tready is high; results pass through the prep
// stages, the eight-stage restoring divider that forms the saturation and hue
// quotients one bit per stage, the classify stages and an output register with
// a one-entry skid stage, which keeps input accepted while one result waits;
// input stalls once the skid entry is full. Hue and saturation windows reset to
// their default colors and may be rewritten through the cfg port whenever the
// stream is idle; writes to an index beyond the window registers are ignored.
module hsv_hue_range_color_classifier #(
  parameter int NUM_CLASSES = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  // color_class[2:0], hue[10:3], saturation[18:11], brightness[26:19], zero[31:27]
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  // window registers
  logic [NUM_CLASSES-1:0][hsvc_pkg::HueRegW-1:0] hue_win_r;
  logic [hsvc_pkg::SatRegW-1:0]                  sat_win_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        hue_win_r[c] <= hsvc_pkg::HueWinReset[c];
      end
      sat_win_r <= hsvc_pkg::SatWinReset;
    end else if (cfg_valid) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (cfg_index == 3'(c)) hue_win_r[c] <= cfg_data;
      end
      if (cfg_index == hsvc_pkg::CfgSatWin) sat_win_r <= cfg_data[15:0];
    end
  end

  // pipeline
  logic                pipe_en;
  logic                prep_valid, div_valid, cls_valid;
  hsvc_pkg::hsvc_ctl_t prep_ctl, div_ctl;
  hsvc_pkg::hsvc_div_t prep_ops;
  logic [7:0]          sat_q, hue_q;
  hsvc_pkg::hsvc_res_t cls_res;

  hsvc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_tvalid),
    .red       (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .blue      (in_tdata[23:16]),
    .out_valid (prep_valid),
    .out_ctl   (prep_ctl),
    .out_ops   (prep_ops)
  );

  hsvc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (prep_valid),
    .in_ops    (prep_ops),
    .in_ctl    (prep_ctl),
    .out_valid (div_valid),
    .out_ctl   (div_ctl),
    .out_sat_q (sat_q),
    .out_hue_q (hue_q)
  );

  hsvc_classify #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (div_valid),
    .in_ctl    (div_ctl),
    .in_sat_q  (sat_q),
    .in_hue_q  (hue_q),
    .hue_win   (hue_win_r),
    .sat_win   (sat_win_r),
    .out_valid (cls_valid),
    .out_res   (cls_res)
  );

  // output register plus skid stage
  logic                out_valid_r, out_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  hsvc_pkg::hsvc_res_t out_data_r, out_data_nxt;
  hsvc_pkg::hsvc_res_t skid_data_r, skid_data_nxt;
  logic                take, out_free;

  assign pipe_en   = !skid_valid_r;
  assign in_tready = pipe_en;
  assign take      = cls_valid && pipe_en;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        // drain the skid entry first
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (take) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = cls_res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (take) begin
      // hold the result that cannot move on yet
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = cls_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_data_r.brightness, out_data_r.saturation,
                       out_data_r.hue, out_data_r.color_class};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && take) |=> skid_valid_r)
    else $error("result arriving under stall was not held in skid");

  a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.brightness == 8'd0) |->
      (out_data_r.saturation == 8'd0 && out_data_r.hue == 8'd0))
    else $error("black color with nonzero hue or saturation");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.hue < 8'd180))
    else $error("hue out of range");

endmodule

// File: bench/hsv_hue_range_color_classifier_tb.sv
`timescale 1ns / 1ps
module hsv_hue_range_color_classifier_tb;

  localparam int NumClasses   = 7;
  localparam int NumPhases    = 10;
  localparam int RandPerPhase = 185;
  localparam int PressurePhase = 4;
  localparam int HoldCycles   = 320;
  localparam int DrainCycles  = 20;

  localparam logic [2:0] ClsRed = 3'd6;

  typedef struct {
    logic [7:0]          r;
    logic [7:0]          g;
    logic [7:0]          b;
    bit                  typed;
    hsvc_pkg::hsvc_res_t res;
  } color_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [17:0] cfg_data;

  logic [hsvc_pkg::HueRegW-1:0] hue_win [hsvc_pkg::MaxHueRegs];
  logic [hsvc_pkg::SatRegW-1:0] sat_win;
  hsvc_pkg::hsvc_res_t          expected_colors [$];
  int                           errors = 0;
  bit                           steady;
  bit                           hold_req;

  color_row_t directed_rows [18] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{ClsRed, 8'd0, 8'd0,   8'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{ClsRed, 8'd0, 8'd0,   8'd255}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{ClsRed, 8'd0, 8'd0,   8'd128}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{ClsRed, 8'd0, 8'd255, 8'd255}},
    '{8'd0,   8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd255, 1'b0, '0},
    '{8'd255, 8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd255, 8'd255, 1'b0, '0},
    '{8'd255, 8'd0,   8'd255, 1'b0, '0},
    '{8'd255, 8'd0,   8'd5,   1'b0, '0},
    '{8'd1,   8'd0,   8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd1,   1'b0, '0},
    '{8'd255, 8'd254, 8'd254, 1'b0, '0},
    '{8'd200, 8'd188, 8'd180, 1'b0, '0},
    '{8'd200, 8'd140, 8'd100, 1'b0, '0},
    '{8'd200, 8'd100, 8'd150, 1'b0, '0},
    '{8'd255, 8'd128, 8'd0,   1'b0, '0},
    '{8'd100, 8'd120, 8'd120, 1'b0, '0}
  };

  hsv_hue_range_color_classifier #(.NUM_CLASSES(NumClasses)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic hsvc_pkg::hsvc_res_t classify_color(input logic [7:0] r, g, b);
    int ri, gi, bi, mx, mn, diff, num, t, h, s, lo, hi, hh, slo, shi;
    hsvc_pkg::hsvc_res_t res;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    mx = ri;
    mn = ri;
    h = 0;
    s = 0;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    diff = mx - mn;
    if (mx > 0) s = (510 * diff + mx) / (2 * mx);
    if (diff > 0) begin
      if (mx == ri) num = gi - bi;
      else if (mx == gi) num = bi - ri + 2 * diff;
      else num = ri - gi + 4 * diff;
      // add 121 * diff so the division never sees a negative numerator
      t = 60 * num + 121 * diff;
      h = t / (2 * diff) - 60;
      if (h < 0) h += int'(hsvc_pkg::HalfTurn);
    end
    res.color_class = hsvc_pkg::ClsNoMatch;
    for (int c = 0; c < NumClasses; c++) begin
      lo = int'($signed(hue_win[c][8:0]));
      hi = int'($signed(hue_win[c][17:9]));
      hh = (h > hi) ? h - int'(hsvc_pkg::HalfTurn) : h;
      if (hh >= lo && hh <= hi) begin
        if (c == hsvc_pkg::ClsWall) begin
          slo = int'(sat_win[7:0]);
          shi = int'(sat_win[15:8]);
          if (s >= slo && s <= shi) res.color_class = hsvc_pkg::ClsWall;
        end else begin
          res.color_class = 3'(c);
        end
      end
    end
    res.hue        = 8'(h);
    res.saturation = 8'(s);
    res.brightness = 8'(mx);
    return res;
  endfunction

  // mostly short idles, now and then a long one; none while steady is set
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [17:0] pack_hue_window(input int lo, input int hi);
    return {hi[8:0], lo[8:0]};
  endfunction

  function automatic logic [17:0] rand_hue_window();
    int lo;
    lo = $urandom_range(0, 200) - 20;
    if ($urandom_range(0, 4) == 0) return 18'($urandom);
    return pack_hue_window(lo, lo + $urandom_range(0, 60));
  endfunction

  function automatic logic [17:0] rand_sat_window();
    int lo;
    lo = $urandom_range(0, 150);
    if ($urandom_range(0, 4) == 0) return 18'($urandom);
    return {2'b00, 8'(lo + $urandom_range(0, 105)), 8'(lo)};
  endfunction

  task automatic rand_color(output logic [7:0] r, g, b);
    int mode;
    logic [7:0] base;
    mode = $urandom_range(0, 9);
    base = 8'($urandom);
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    case (mode)
      5: begin
        g = r;
        b = r;
      end
      6: begin
        if ($urandom_range(0, 1)) r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 1)) g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 1)) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      7: begin
        r = 8'($urandom_range(0, 3));
        g = 8'($urandom_range(0, 3));
        b = 8'($urandom_range(0, 3));
      end
      8: begin
        // near grey: low saturation, hue spread over the whole circle
        base = 8'($urandom_range(20, 230));
        r = base + 8'($urandom_range(0, 25));
        g = base + 8'($urandom_range(0, 25));
        b = base + 8'($urandom_range(0, 25));
      end
      9: begin
        case ($urandom_range(0, 2))
          0: r = 8'hFF;
          1: g = 8'hFF;
          default: b = 8'hFF;
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx < hsvc_pkg::CfgSatWin) hue_win[idx] = val;
    else sat_win = val[hsvc_pkg::SatRegW-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_windows(input int phase);
    logic [17:0] hue_val;
    logic [17:0] sat_val;
    for (int i = 0; i < hsvc_pkg::MaxHueRegs; i++) begin
      case (phase)
        1: hue_val = '0;
        2: hue_val = '1;
        3: hue_val = pack_hue_window(100, 50);
        4: hue_val = (i == hsvc_pkg::ClsWall) ? pack_hue_window(-256, 255)
                                              : pack_hue_window(60, -60);
        9: hue_val = hsvc_pkg::HueWinReset[i];
        default: hue_val = rand_hue_window();
      endcase
      write_reg(3'(i), hue_val);
    end
    case (phase)
      1: sat_val = '0;
      2: sat_val = '1;
      3: sat_val = {2'b00, 8'd10, 8'd200};
      4: sat_val = {2'b11, 8'hFF, 8'h00};
      9: sat_val = {2'b00, hsvc_pkg::SatWinReset};
      default: sat_val = rand_sat_window();
    endcase
    write_reg(hsvc_pkg::CfgSatWin, sat_val);
  endtask

  task automatic send_color(input logic [7:0] r, g, b, input bit typed,
                            input hsvc_pkg::hsvc_res_t res);
    int gap;
    hsvc_pkg::hsvc_res_t want;
    in_tdata  = {b, g, r};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    want = typed ? res : classify_color(r, g, b);
    expected_colors.insert(expected_colors.size(), want);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (expected_colors.size() > 0) @(negedge clk);
  endtask

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // stimulus and configuration
  initial begin
    logic [7:0] r, g, b;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    for (int i = 0; i < hsvc_pkg::MaxHueRegs; i++) hue_win[i] = hsvc_pkg::HueWinReset[i];
    sat_win = hsvc_pkg::SatWinReset;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase > 0) begin
        wait_drained();
        repeat (16) @(negedge clk);
        set_windows(phase);
      end
      steady = (phase == PressurePhase || phase == 7);
      if (phase == 0) begin
        foreach (directed_rows[i])
          send_color(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b,
                     directed_rows[i].typed, directed_rows[i].res);
      end
      // stall the output while the input keeps streaming
      if (phase == PressurePhase) hold_req = 1'b1;
      repeat (RandPerPhase) begin
        rand_color(r, g, b);
        send_color(r, g, b, 1'b0, '0);
      end
      in_tvalid = 1'b0;
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("[hsv_hue_range_color_classifier] OK");
    end else begin
      $display("[hsv_hue_range_color_classifier] ERROR");
    end
    $finish;
  end

  // result sink with random back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_results
    hsvc_pkg::hsvc_res_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
        errors++;
      end else begin
        want = expected_colors.pop_front();
        cmp_field("color_class", {5'b0, want.color_class}, {5'b0, out_tdata[2:0]});
        cmp_field("hue", want.hue, out_tdata[10:3]);
        cmp_field("saturation", want.saturation, out_tdata[18:11]);
        cmp_field("brightness", want.brightness, out_tdata[26:19]);
        cmp_field("padding", 8'd0, {3'b0, out_tdata[31:27]});
      end
    end
  end

  initial begin
    #(6_000_000);
    $display("[hsv_hue_range_color_classifier] ERROR");
    $finish;
  end

endmodule

// File: hsv_hue_range_color_classifier.f
design/hsvc_pkg.sv
design/hsvc_prep.sv
design/hsvc_div.sv
design/hsvc_classify.sv
design/hsv_hue_range_color_classifier.sv
bench/hsv_hue_range_color_classifier_tb.sv
